// File: rtl/lzbd_pkg.sv
`default_nettype none
package lzbd_pkg;

  localparam int unsigned ADDR_MAX_W  = 16;
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);
  localparam logic [15:0] CW_MARK     = 16'h8000;
  localparam logic [13:0] LONG_SPAN   = 14'd8192;
  localparam logic [8:0]  MIN_MATCH   = 9'd2;
  localparam logic [3:0]  HDR_RESET   = 4'd6;

  typedef enum logic [1:0] {
    CMD_LIT,
    CMD_COPY,
    CMD_END
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e              kind;
    logic [7:0]             data;
    logic [8:0]             len;
    logic [ADDR_MAX_W-1:0]  src;
    logic [ADDR_MAX_W-1:0]  dst;
  } cmd_t;

  typedef enum logic [3:0] {
    PH_ENDED,
    PH_HEADER,
    PH_LIT,
    PH_SDISP,
    PH_LLO,
    PH_LHI,
    PH_EXT,
    PH_CWLO,
    PH_CWHI
  } phase_e;

  typedef enum logic [1:0] {
    CTX_TOP,
    CTX_SECOND,
    CTX_LEN1,
    CTX_LEN2
  } ctx_e;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_READ,
    BK_WRITE,
    BK_FLUSH
  } back_state_e;

endpackage
`default_nettype wire

// File: rtl/lz_bitstream_decompressor_top.sv
// LZ bit-stream decompressor.
// Input stream s_axis: one compressed byte per item, tuser marks the first
// byte of a payload. Output stream m_axis: beats of up to LANES decoded
// bytes, tlast closes the beats caused by one input byte, tuser flags the
// end-of-payload beat (byte count 0).
// cfg_wen_i/cfg_wdata_i set the number of header bytes skipped (reset 6).
// The parser takes one byte per cycle while its four-entry command queue has
// room. The copy engine writes each literal byte directly and handles each
// match byte as a history read, then a write; it loads the output register
// once per beat. The registered read port of the history memory sets this.
// With the engine idle, the first result of a command passes through the
// command queue and the engine states into the output register. Reset clears
// the control state; history contents are undefined until written. A stalled
// receiver holds the output register, the engine waits, then the queue fills
// and s_axis_tready drops.
`default_nettype none
module lz_bitstream_decompressor_top import lzbd_pkg::*; #(
  parameter int unsigned HISTORY_DEPTH = 8192,
  parameter int unsigned LANES         = 8
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       s_axis_tvalid,
  output logic            s_axis_tready,
  input  wire logic [7:0] s_axis_tdata,  // in_byte
  input  wire logic       s_axis_tuser,  // start_of_payload
  output logic            m_axis_tvalid,
  input  wire logic       m_axis_tready,
  // out_byte_0 .. out_byte_(LANES-1), byte_count, zero fill
  output logic [((LANES*8+$clog2(LANES+1)+7)/8)*8-1:0] m_axis_tdata,
  output logic            m_axis_tlast,
  output logic            m_axis_tuser,  // end_of_payload
  input  wire logic       cfg_wen_i,
  input  wire logic [3:0] cfg_wdata_i
);

  localparam int unsigned AW = $clog2(HISTORY_DEPTH);
  localparam int unsigned CW = $clog2(LANES + 1);
  localparam int unsigned DW = ((LANES*8 + CW + 7) / 8) * 8;

  logic [3:0]         hdr_q;
  logic               f_valid, q_full_n, q_nempty, b_ready;
  cmd_t               f_cmd, q_cmd;
  logic [LANES*8-1:0] o_bytes;
  logic [CW-1:0]      o_cnt;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hdr_q <= HDR_RESET;
    end else if (cfg_wen_i) begin
      hdr_q <= cfg_wdata_i;
    end
  end

  lzbd_front #(.AW(AW)) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (s_axis_tvalid),
    .in_ready_o     (s_axis_tready),
    .in_byte_i      (s_axis_tdata),
    .start_i        (s_axis_tuser),
    .header_bytes_i (hdr_q),
    .cmd_valid_o    (f_valid),
    .cmd_o          (f_cmd),
    .cmd_ready_i    (q_full_n)
  );

  lzbd_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (f_valid),
    .push_data_i (f_cmd),
    .not_full_o  (q_full_n),
    .not_empty_o (q_nempty),
    .pop_i       (b_ready),
    .pop_data_o  (q_cmd)
  );

  lzbd_back #(.AW(AW), .LANES(LANES), .CW(CW)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (q_nempty),
    .cmd_i       (q_cmd),
    .cmd_ready_o (b_ready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_bytes_o (o_bytes),
    .out_count_o (o_cnt),
    .out_last_o  (m_axis_tlast),
    .out_end_o   (m_axis_tuser)
  );

  assign m_axis_tdata = DW'({o_cnt, o_bytes});

endmodule
`default_nettype wire

// File: rtl/lzbd_front.sv
`default_nettype none
module lzbd_front import lzbd_pkg::*; #(
  parameter int unsigned AW = 13
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic [7:0] in_byte_i,
  input  wire logic       start_i,
  input  wire logic [3:0] header_bytes_i,
  output logic            cmd_valid_o,
  output cmd_t            cmd_o,
  input  wire logic       cmd_ready_i
);

  typedef struct packed {
    phase_e      phase;
    ctx_e        ctx;
    logic [15:0] cs;
    logic [8:0]  plen;
  } settle_t;

  function automatic settle_t settle(ctx_e ctx, logic have, logic b,
                                     logic [15:0] cs, logic [8:0] plen);
    settle_t r;
    logic    done;
    logic    bv;
    logic    h;
    ctx_e    c;
    r.cs    = cs;
    r.plen  = plen;
    r.phase = PH_ENDED;
    r.ctx   = ctx;
    c       = ctx;
    h       = have;
    bv      = b;
    done    = 1'b0;
    for (int i = 0; i < 4; i++) begin
      if (!done) begin
        if (!h) begin
          bv   = r.cs[0];
          r.cs = {1'b0, r.cs[15:1]};
        end
        if (!h && r.cs == 16'd0) begin
          r.phase = PH_CWLO;
          r.ctx   = c;
          done    = 1'b1;
        end else begin
          h = 1'b0;
          unique case (c)
            CTX_TOP: begin
              if (bv) begin
                r.phase = PH_LIT;
                done    = 1'b1;
              end else begin
                c = CTX_SECOND;
              end
            end
            CTX_SECOND: begin
              if (bv) begin
                r.phase = PH_LLO;
                done    = 1'b1;
              end else begin
                r.plen = 9'd0;
                c      = CTX_LEN1;
              end
            end
            CTX_LEN1: begin
              r.plen = {8'd0, bv};
              c      = CTX_LEN2;
            end
            default: begin
              r.plen  = {r.plen[7:0], bv};
              r.phase = PH_SDISP;
              done    = 1'b1;
            end
          endcase
        end
      end
    end
    return r;
  endfunction

  phase_e        phase_q, phase_d;
  ctx_e          ctx_q, ctx_d;
  logic [15:0]   cs_q, cs_d;
  logic [7:0]    held_q, held_d;
  logic [8:0]    plen_q, plen_d;
  logic [13:0]   pdist_q, pdist_d;
  logic [3:0]    hl_q, hl_d;
  logic [AW-1:0] wp_q, wp_d;
  logic          accept;

  assign in_ready_o = cmd_ready_i;
  assign accept     = in_valid_i && cmd_ready_i;

  always_comb begin
    settle_t       s;
    logic [15:0]   w;
    logic [8:0]    len;
    logic [AW:0]   back_src;
    logic [AW-1:0] src;
    phase_d     = phase_q;
    ctx_d       = ctx_q;
    cs_d        = cs_q;
    held_d      = held_q;
    plen_d      = plen_q;
    pdist_d     = pdist_q;
    hl_d        = hl_q;
    wp_d        = wp_q;
    cmd_valid_o = 1'b0;
    cmd_o       = '0;
    s           = '0;
    w           = {in_byte_i, held_q};
    len         = '0;
    back_src    = '0;
    src         = '0;
    if (accept) begin
      if (start_i) begin
        wp_d    = '0;
        cs_d    = '0;
        held_d  = '0;
        plen_d  = '0;
        pdist_d = '0;
        hl_d    = header_bytes_i;
        if (header_bytes_i != 4'd0) begin
          phase_d = PH_HEADER;
        end else begin
          s       = settle(CTX_TOP, 1'b0, 1'b0, cs_d, plen_d);
          phase_d = s.phase;
          ctx_d   = s.ctx;
          cs_d    = s.cs;
          plen_d  = s.plen;
        end
      end
      w = {in_byte_i, held_d};
      unique case (phase_d)
        PH_HEADER: begin
          hl_d = hl_d - 4'd1;
          if (hl_d == 4'd0) begin
            s       = settle(CTX_TOP, 1'b0, 1'b0, cs_d, plen_d);
            phase_d = s.phase;
            ctx_d   = s.ctx;
            cs_d    = s.cs;
            plen_d  = s.plen;
          end
        end
        PH_LIT: begin
          cmd_valid_o = 1'b1;
          cmd_o.kind  = CMD_LIT;
          cmd_o.data  = in_byte_i;
          cmd_o.len   = 9'd1;
          cmd_o.dst   = ADDR_MAX_W'(wp_d);
          wp_d        = wp_d + AW'(1);
          s           = settle(CTX_TOP, 1'b0, 1'b0, cs_d, plen_d);
          phase_d     = s.phase;
          ctx_d       = s.ctx;
          cs_d        = s.cs;
          plen_d      = s.plen;
        end
        PH_SDISP: begin
          src         = wp_d + {{(AW-8){in_byte_i[7]}}, in_byte_i};
          len         = plen_d + MIN_MATCH;
          cmd_valid_o = 1'b1;
          cmd_o.kind  = CMD_COPY;
          cmd_o.len   = len;
          cmd_o.src   = ADDR_MAX_W'(src);
          cmd_o.dst   = ADDR_MAX_W'(wp_d);
          wp_d        = wp_d + AW'(len);
          s           = settle(CTX_TOP, 1'b0, 1'b0, cs_d, plen_d);
          phase_d     = s.phase;
          ctx_d       = s.ctx;
          cs_d        = s.cs;
          plen_d      = s.plen;
        end
        PH_LLO: begin
          held_d  = in_byte_i;
          phase_d = PH_LHI;
        end
        PH_LHI: begin
          pdist_d = LONG_SPAN - {1'b0, w[15:3]};
          plen_d  = {6'd0, w[2:0]};
          if (w[2:0] == 3'd0) begin
            phase_d = PH_EXT;
          end else begin
            back_src    = {1'b0, wp_d} - (AW+1)'(pdist_d);
            len         = plen_d + MIN_MATCH;
            cmd_valid_o = 1'b1;
            cmd_o.kind  = CMD_COPY;
            cmd_o.len   = len;
            cmd_o.src   = ADDR_MAX_W'(back_src[AW-1:0]);
            cmd_o.dst   = ADDR_MAX_W'(wp_d);
            wp_d        = wp_d + AW'(len);
            s           = settle(CTX_TOP, 1'b0, 1'b0, cs_d, plen_d);
            phase_d     = s.phase;
            ctx_d       = s.ctx;
            cs_d        = s.cs;
            plen_d      = s.plen;
          end
        end
        PH_EXT: begin
          cmd_valid_o = 1'b1;
          if (in_byte_i == 8'd0) begin
            cmd_o.kind = CMD_END;
            phase_d    = PH_ENDED;
          end else begin
            plen_d     = {1'b0, in_byte_i};
            back_src   = {1'b0, wp_d} - (AW+1)'(pdist_d);
            len        = plen_d + MIN_MATCH;
            cmd_o.kind = CMD_COPY;
            cmd_o.len  = len;
            cmd_o.src  = ADDR_MAX_W'(back_src[AW-1:0]);
            cmd_o.dst  = ADDR_MAX_W'(wp_d);
            wp_d       = wp_d + AW'(len);
            s          = settle(CTX_TOP, 1'b0, 1'b0, cs_d, plen_d);
            phase_d    = s.phase;
            ctx_d      = s.ctx;
            cs_d       = s.cs;
            plen_d     = s.plen;
          end
        end
        PH_CWLO: begin
          held_d  = in_byte_i;
          phase_d = PH_CWHI;
        end
        PH_CWHI: begin
          cs_d    = {1'b0, w[15:1]} | CW_MARK;
          s       = settle(ctx_d, 1'b1, w[0], cs_d, plen_d);
          phase_d = s.phase;
          ctx_d   = s.ctx;
          cs_d    = s.cs;
          plen_d  = s.plen;
        end
        default: begin
          phase_d = phase_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_ENDED;
      ctx_q   <= CTX_TOP;
      cs_q    <= '0;
      held_q  <= '0;
      plen_q  <= '0;
      pdist_q <= '0;
      hl_q    <= '0;
      wp_q    <= '0;
    end else begin
      phase_q <= phase_d;
      ctx_q   <= ctx_d;
      cs_q    <= cs_d;
      held_q  <= held_d;
      plen_q  <= plen_d;
      pdist_q <= pdist_d;
      hl_q    <= hl_d;
      wp_q    <= wp_d;
    end
  end

endmodule
`default_nettype wire

// File: rtl/lzbd_queue.sv
`default_nettype none
module lzbd_queue import lzbd_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  wire cmd_t push_data_i,
  output logic      not_full_o,
  output logic      not_empty_o,
  input  wire logic pop_i,
  output cmd_t      pop_data_o
);

  cmd_t                mem_q [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_q, rd_q;
  logic [QUEUE_AW:0]   cnt_q;
  logic                do_push, do_pop;

  assign not_full_o  = cnt_q != (QUEUE_AW+1)'(QUEUE_DEPTH);
  assign not_empty_o = cnt_q != '0;
  assign do_push     = push_i && not_full_o;
  assign do_pop      = pop_i && not_empty_o;
  assign pop_data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= wr_q + QUEUE_AW'(1);
      end
      if (do_pop) begin
        rd_q <= rd_q + QUEUE_AW'(1);
      end
      unique case ({do_push, do_pop})
        2'b10:   cnt_q <= cnt_q + (QUEUE_AW+1)'(1);
        2'b01:   cnt_q <= cnt_q - (QUEUE_AW+1)'(1);
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule
`default_nettype wire

// File: rtl/lzbd_back.sv
`default_nettype none
module lzbd_back import lzbd_pkg::*; #(
  parameter int unsigned AW    = 13,
  parameter int unsigned LANES = 8,
  parameter int unsigned CW    = $clog2(LANES + 1)
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          cmd_valid_i,
  input  wire cmd_t          cmd_i,
  output logic               cmd_ready_o,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  output logic [LANES*8-1:0] out_bytes_o,
  output logic [CW-1:0]      out_count_o,
  output logic               out_last_o,
  output logic               out_end_o
);

  localparam int unsigned LW = $clog2(LANES);

  logic [7:0]         mem [2**AW];
  logic [7:0]         rd_q;
  back_state_e        state_q, state_d;
  cmd_kind_e          kind_q, kind_d;
  logic [7:0]         data_q, data_d;
  logic [AW-1:0]      src_q, src_d, dst_q, dst_d;
  logic [8:0]         left_q, left_d;
  logic [CW-1:0]      lane_q, lane_d;
  logic [LANES*8-1:0] buf_q, buf_d;
  logic               ov_q, ov_d, olast_q, olast_d, oend_q, oend_d;
  logic [LANES*8-1:0] obuf_q, obuf_d;
  logic [CW-1:0]      ocnt_q, ocnt_d;
  logic               out_free, we;
  logic [7:0]         wbyte;

  assign out_free    = !ov_q || out_ready_i;
  assign cmd_ready_o = state_q == BK_IDLE;
  assign we          = state_q == BK_WRITE;
  assign wbyte       = (kind_q == CMD_LIT) ? data_q : rd_q;
  assign out_valid_o = ov_q;
  assign out_bytes_o = obuf_q;
  assign out_count_o = ocnt_q;
  assign out_last_o  = olast_q;
  assign out_end_o   = oend_q;

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[dst_q] <= wbyte;
    end
    rd_q <= mem[src_q];
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      BK_IDLE: begin
        if (cmd_valid_i) begin
          unique case (cmd_i.kind)
            CMD_LIT:  state_d = BK_WRITE;
            CMD_COPY: state_d = BK_READ;
            default:  state_d = BK_FLUSH;
          endcase
        end
      end
      BK_READ:  state_d = BK_WRITE;
      BK_WRITE: begin
        if (lane_q + CW'(1) == CW'(LANES) || left_q == 9'd1) begin
          state_d = BK_FLUSH;
        end else begin
          state_d = BK_READ;
        end
      end
      default: begin
        if (out_free) begin
          state_d = (left_q == 9'd0) ? BK_IDLE : BK_READ;
        end
      end
    endcase
  end

  always_comb begin
    kind_d  = kind_q;
    data_d  = data_q;
    src_d   = src_q;
    dst_d   = dst_q;
    left_d  = left_q;
    lane_d  = lane_q;
    buf_d   = buf_q;
    ov_d    = ov_q && !out_ready_i;
    obuf_d  = obuf_q;
    ocnt_d  = ocnt_q;
    olast_d = olast_q;
    oend_d  = oend_q;
    unique case (state_q)
      BK_IDLE: begin
        if (cmd_valid_i) begin
          kind_d = cmd_i.kind;
          data_d = cmd_i.data;
          src_d  = cmd_i.src[AW-1:0];
          dst_d  = cmd_i.dst[AW-1:0];
          left_d = (cmd_i.kind == CMD_END) ? 9'd0 : cmd_i.len;
          lane_d = '0;
          buf_d  = '0;
        end
      end
      BK_READ: begin
        kind_d = kind_q;
      end
      BK_WRITE: begin
        buf_d[lane_q[LW-1:0]*8 +: 8] = wbyte;
        lane_d = lane_q + CW'(1);
        left_d = left_q - 9'd1;
        src_d  = src_q + AW'(1);
        dst_d  = dst_q + AW'(1);
      end
      default: begin
        if (out_free) begin
          ov_d    = 1'b1;
          obuf_d  = buf_q;
          ocnt_d  = lane_q;
          olast_d = left_q == 9'd0;
          oend_d  = kind_q == CMD_END;
          buf_d   = '0;
          lane_d  = '0;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BK_IDLE;
      ov_q    <= 1'b0;
      lane_q  <= '0;
      left_q  <= '0;
    end else begin
      state_q <= state_d;
      ov_q    <= ov_d;
      lane_q  <= lane_d;
      left_q  <= left_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q  <= kind_d;
    data_q  <= data_d;
    src_q   <= src_d;
    dst_q   <= dst_d;
    buf_q   <= buf_d;
    obuf_q  <= obuf_d;
    ocnt_q  <= ocnt_d;
    olast_q <= olast_d;
    oend_q  <= oend_d;
  end

endmodule
`default_nettype wire

// File: rtl/lzbd_checker.sv
`default_nettype none
module lzbd_checker #(
  parameter int unsigned LANES = 8,
  parameter int unsigned DW    = 72
) (
  input wire logic          clk_i,
  input wire logic          rst_ni,
  input wire logic          m_axis_tvalid,
  input wire logic          m_axis_tready,
  input wire logic [DW-1:0] m_axis_tdata,
  input wire logic          m_axis_tlast,
  input wire logic          m_axis_tuser
);

  localparam int unsigned CW = $clog2(LANES + 1);

  logic [CW-1:0] cnt;
  assign cnt = m_axis_tdata[LANES*8 +: CW];

  a_end_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> cnt == '0 && m_axis_tlast)
    else $error("end beat malformed");

  a_data_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> cnt != '0 && cnt <= CW'(LANES))
    else $error("bad byte count");

  a_partial_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser && cnt != CW'(LANES) |-> m_axis_tlast)
    else $error("partial beat not last");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled beat changed");

endmodule

bind lz_bitstream_decompressor_top lzbd_checker #(.LANES(LANES), .DW(DW)) u_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast),
  .m_axis_tuser  (m_axis_tuser)
);
`default_nettype wire
